// File: hdl/atpc_pkg.sv
`timescale 1ns / 1ps

package atpc_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int TEMP_W    = 15;
    localparam int GAIN_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 15;

    // 256 * 3.3 / 0.005, temperature scale in Q7.8 per converter code
    localparam int CONV_W = 18;
    localparam logic [CONV_W-1:0] CONV_NUM = 18'd168960;
    localparam int FULL_SCALE = 4095;

    // quotient never exceeds CONV_NUM
    localparam int QUOT_W = 18;

    localparam int GAIN_SHIFT = 8;

    localparam logic [CFG_W-1:0]  TARGET_RST = 15'd0;
    localparam logic [GAIN_W-1:0] GAIN_RST   = 8'd40;
    localparam logic [TEMP_W-1:0] UPPER_RST  = 15'd25600;
    localparam logic [TEMP_W-1:0] LOWER_RST  = 15'd1280;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE   = 3'd0,
        REG_TARGET = 3'd1,
        REG_GAIN   = 3'd2,
        REG_UPPER  = 3'd3,
        REG_LOWER  = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        MODE_HEAT = 1'b0,
        MODE_COOL = 1'b1
    } ctrl_mode_t;

endpackage

// File: hdl/averaged_temperature_p_control_top.sv
`timescale 1ns / 1ps

// channel   dir  handshake            payload
// s_        in   s_valid / s_ready    s_sample
// m_        out  m_valid / m_ready    m_temperature, m_drive, m_done_res
// cfg_      in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// samples are taken one per cycle while a group accumulates
// the last sample of a group drops s_ready for the busy states: two passes of the
// shared multiplier by the divisor reciprocal, clamp, error, drive multiply
// aresetn is synchronous: clears the group sum and count and loads register defaults
// a result waits in the output register; the next group accumulates meanwhile and
// only stalls if its result is ready before the previous one is taken
// cfg_ready is always high

module averaged_temperature_p_control_top #(
    parameter int SAMPLES_PER_DECISION = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [atpc_pkg::SAMPLE_W-1:0]    s_sample,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [atpc_pkg::TEMP_W-1:0]      m_temperature,
    output logic [atpc_pkg::TEMP_W-1:0]      m_drive,
    output logic                             m_done_res,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [atpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [atpc_pkg::CFG_W-1:0]       cfg_data
);

    import atpc_pkg::*;

    localparam int DIVISOR_VAL = FULL_SCALE * SAMPLES_PER_DECISION;
    localparam int SUM_W       = $clog2(DIVISOR_VAL + 1);
    localparam int CNT_W       = (SAMPLES_PER_DECISION > 1) ? $clog2(SAMPLES_PER_DECISION) : 1;
    localparam int DPROD_W     = TEMP_W + GAIN_W;

    // reciprocal scaled so that the floor is exact for every group sum
    localparam int          RECIP_SHIFT = 2 * SUM_W;
    localparam logic [63:0] RECIP       = ((64'(CONV_NUM) << RECIP_SHIFT)
                                          + 64'(DIVISOR_VAL) - 64'd1) / 64'(DIVISOR_VAL);
    localparam int          RECIP_W     = $clog2(RECIP + 64'd1);
    localparam int          RLO_W       = (RECIP_W + 1) / 2;
    localparam int          ACC_W       = RECIP_SHIFT + QUOT_W;
    localparam int          MUL_W       = SUM_W + RLO_W;

    localparam logic [RLO_W-1:0] RECIP_LO = RECIP[RLO_W-1:0];
    localparam logic [RLO_W-1:0] RECIP_HI = RLO_W'(RECIP >> RLO_W);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_PER_DECISION - 1);

    typedef enum logic [2:0] {
        ST_ACC,
        ST_LOAD,
        ST_MULH,
        ST_CLAMP,
        ST_ERR,
        ST_DRIVE
    } state_t;

    state_t               state_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic [TEMP_W-1:0]    temp_reg;
    logic [TEMP_W-1:0]    err_reg;
    logic                 done_reg;

    ctrl_mode_t           mode_reg;
    logic [TEMP_W-1:0]    target_reg;
    logic [GAIN_W-1:0]    gain_reg;
    logic [TEMP_W-1:0]    upper_reg;
    logic [TEMP_W-1:0]    lower_reg;

    logic                 m_valid_reg;
    logic [TEMP_W-1:0]    m_temperature_reg;
    logic [TEMP_W-1:0]    m_drive_reg;
    logic                 m_done_reg;

    logic [SUM_W-1:0]     sum_next;
    logic [RLO_W-1:0]     mul_op;
    logic [MUL_W-1:0]     mul_out;
    logic [QUOT_W-1:0]    quo;
    logic [TEMP_W-1:0]    clamp_hi;
    logic [TEMP_W-1:0]    clamp_val;
    logic [DPROD_W-1:0]   drive_prod;
    logic                 s_xfer;

    assign s_ready   = (state_reg == ST_ACC);
    assign s_xfer    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign m_valid       = m_valid_reg;
    assign m_temperature = m_temperature_reg;
    assign m_drive       = m_drive_reg;
    assign m_done_res    = m_done_reg;

    assign sum_next = sum_reg + SUM_W'(s_sample);

    // shared multiplier: low half of the reciprocal first, then the high half
    assign mul_op  = (state_reg == ST_LOAD) ? RECIP_LO : RECIP_HI;
    assign mul_out = MUL_W'(sum_reg) * MUL_W'(mul_op);
    assign quo     = acc_reg[RECIP_SHIFT +: QUOT_W];

    assign clamp_hi  = (quo > QUOT_W'(upper_reg)) ? upper_reg : quo[TEMP_W-1:0];
    assign clamp_val = (clamp_hi < lower_reg) ? lower_reg : clamp_hi;

    assign drive_prod = DPROD_W'(err_reg) * DPROD_W'(gain_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_ACC;
            sum_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            mode_reg    <= MODE_HEAT;
            target_reg  <= TARGET_RST;
            gain_reg    <= GAIN_RST;
            upper_reg   <= UPPER_RST;
            lower_reg   <= LOWER_RST;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_MODE:   mode_reg   <= ctrl_mode_t'(cfg_data[0]);
                    REG_TARGET: target_reg <= cfg_data[TEMP_W-1:0];
                    REG_GAIN:   gain_reg   <= cfg_data[GAIN_W-1:0];
                    REG_UPPER:  upper_reg  <= cfg_data[TEMP_W-1:0];
                    REG_LOWER:  lower_reg  <= cfg_data[TEMP_W-1:0];
                    default: ;
                endcase
            end

            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_ACC: begin
                    if (s_xfer) begin
                        sum_reg <= sum_next;
                        if (cnt_reg == LAST_CNT) begin
                            cnt_reg   <= '0;
                            state_reg <= ST_LOAD;
                        end else begin
                            cnt_reg <= cnt_reg + CNT_W'(1);
                        end
                    end
                end
                ST_LOAD: begin
                    acc_reg   <= ACC_W'(mul_out);
                    state_reg <= ST_MULH;
                end
                ST_MULH: begin
                    acc_reg   <= acc_reg + (ACC_W'(mul_out) << RLO_W);
                    sum_reg   <= '0;
                    state_reg <= ST_CLAMP;
                end
                ST_CLAMP: begin
                    temp_reg  <= clamp_val;
                    state_reg <= ST_ERR;
                end
                ST_ERR: begin
                    if (mode_reg == MODE_HEAT) begin
                        done_reg <= (target_reg < temp_reg);
                        err_reg  <= target_reg - temp_reg;
                    end else begin
                        done_reg <= (temp_reg < target_reg);
                        err_reg  <= temp_reg - target_reg;
                    end
                    state_reg <= ST_DRIVE;
                end
                ST_DRIVE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg       <= 1'b1;
                        m_temperature_reg <= temp_reg;
                        m_done_reg        <= done_reg;
                        m_drive_reg       <= done_reg ? '0
                                                      : drive_prod[GAIN_SHIFT +: TEMP_W];
                        state_reg         <= ST_ACC;
                    end
                end
                default: state_reg <= ST_ACC;
            endcase
        end
    end

endmodule

// File: hdl/atpc_checker.sv
`timescale 1ns / 1ps

module atpc_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [atpc_pkg::TEMP_W-1:0]      m_temperature,
    input logic [atpc_pkg::TEMP_W-1:0]      m_drive,
    input logic                             m_done_res
);

    // a stalled result keeps its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_temperature)
            && $stable(m_drive) && $stable(m_done_res))
        else $error("result changed while stalled");

    // target passed means no drive
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> m_drive == '0)
        else $error("drive not zero with done set");

    // a fresh result appears as the block goes back to taking samples
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result raised while input still blocked");

    // no result straight out of reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind averaged_temperature_p_control_top atpc_checker u_atpc_checker (.*);
